FILE: rtl/epsa_pkg.sv
// shared constants for the edge period speed averager
// no dependencies; imported by edge_period_speed_averager_core
package epsa_pkg;

    // configuration port
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic [0:0] REG_IDX_PPR = 1'b0;

    // field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SPEED_W = 32;
    localparam int unsigned PPR_W   = 8;

    // fixed constants of the speed conversion
    localparam logic [PPR_W-1:0]   PPR_RESET   = 8'd36;
    localparam int unsigned        SEC_PER_MIN = 60;
    localparam int unsigned        FRAC_BITS   = 8;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 32'hFFFF_FFFF;

endpackage

FILE: rtl/edge_period_speed_averager_core.sv
// hall edge period tachometer with a moving-average window
// depends on epsa_pkg for widths, register index and conversion constants

// Each input transfer carries the microsecond timestamp of one sensor edge.
// The block takes the interval since the previous edge (modulo 2^32),
// converts it to rpm with 8 fraction bits as
// 60 * TICKS_PER_SECOND * 256 / (interval * pulses_per_rev), truncated and
// saturated to 0xFFFFFFFF on a zero divisor or overflow, stores that speed in
// a ring of WINDOW_LEN entries and returns the truncated mean of the ring
// (kept as a running sum) together with the instant speed. The first edge
// after reset only records its time and produces no output transfer; empty
// ring entries count as zero. The speed division runs on a restoring divider
// that retires one quotient bit per cycle. The mean divides the running sum
// by WINDOW_LEN in two 16-bit digits, each by a reciprocal multiply on one
// shared multiplier, with a remainder state between them to form the digit
// remainder. An edge occupies the block through the multiply, the speed
// division, the ring update, the two mean digits and the write-back, and
// in_stall stays high meanwhile. A finished result sits in the output
// register, so the next edge is taken while it waits; only the final
// write-back waits for the output to drain, and stretches the edge for as
// long as the previous result stays stalled. The first edge after reset is
// taken without leaving the idle state. pulses_per_rev sits at byte address
// 0 of the APB port (reset 36); the user must write it only while the block
// is idle, which the block does not enforce. No clearing pass after reset.
module edge_period_speed_averager_core
    import epsa_pkg::*;
#(
    parameter int unsigned WINDOW_LEN       = 20,
    parameter int unsigned TICKS_PER_SECOND = 1000000
) (
    input  logic               clk,
    input  logic               rst_n,
    // edge channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [TIME_W-1:0]  edge_time_us,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SPEED_W-1:0] average_rpm,
    output logic [SPEED_W-1:0] instant_rpm,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    // conversion numerator, fixed at elaboration
    localparam longint unsigned NUMER =
        (64'(SEC_PER_MIN) * 64'(TICKS_PER_SECOND)) << FRAC_BITS;
    localparam int unsigned NW = $clog2(NUMER + 64'd1);
    // dividend and quotient width, always above the speed width
    localparam int unsigned QW = (NW > SPEED_W + 1) ? NW : SPEED_W + 1;
    // divisor width: interval times pulses per revolution
    localparam int unsigned DW = TIME_W + PPR_W;
    localparam int unsigned CNT_W = $clog2(QW);
    // running sum width and ring index width
    localparam int unsigned XW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int unsigned TW = SPEED_W + XW;
    localparam int unsigned PW = XW;
    localparam logic [TW-1:0] TOTAL_MAX = TW'(WINDOW_LEN) * TW'(SPEED_MAX);
    // mean digits: the low digit dividend is a remainder below WINDOW_LEN and 16 sum bits
    localparam int unsigned HALF_W = SPEED_W / 2;
    localparam int unsigned CW = XW + HALF_W;
    // reciprocal shift large enough for an exact quotient over the digit dividend
    localparam int unsigned RS = CW + XW;
    localparam int unsigned MW = CW + 2;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << RS) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_SPD,
        S_SPD_END,
        S_AVG_HI,
        S_AVG_REM,
        S_AVG_LO,
        S_DONE
    } state_t;

    // control and architectural state
    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PPR_W-1:0]    ppr_reg;
    logic [TIME_W-1:0]   prev_time_reg;
    logic                seen_reg;
    logic [PW-1:0]       pos_reg;
    logic [TW-1:0]       total_reg;
    logic [WINDOW_LEN-1:0] vld_reg;
    logic                out_valid_reg;
    logic [SPEED_W-1:0]  average_reg;
    logic [SPEED_W-1:0]  instant_reg;

    // datapath registers
    logic [TIME_W-1:0]   elapsed_reg;
    logic [DW-1:0]       div_reg;
    logic [DW-1:0]       rem_reg;
    logic [QW-1:0]       dvd_reg;
    logic [QW-1:0]       quo_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [SPEED_W-1:0]  rd_data_reg;
    logic                old_vld_reg;
    logic [SPEED_W-1:0]  avg_quo_reg;
    logic [XW-1:0]       avg_rem_reg;

    // speed ring
    logic [SPEED_W-1:0]  ring_mem [WINDOW_LEN];

    logic                in_take;
    logic                out_take;
    logic                cfg_write;
    logic [DW-1:0]       prod;
    logic [DW:0]         rem_sh;
    logic [DW:0]         rem_diff;
    logic                rem_ge;
    logic [DW-1:0]       rem_next;
    logic [QW-1:0]       quo_next;
    logic [SPEED_W-1:0]  speed_sat;
    logic [SPEED_W-1:0]  old_speed;
    logic [TW-1:0]       total_next;
    logic [PW-1:0]       pos_next;
    logic [CW-1:0]       chunk_cur;
    logic [CW+MW-1:0]    chunk_prod;
    logic [HALF_W-1:0]   chunk_quo;
    logic [CW-1:0]       chunk_rem;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign average_rpm = average_reg;
    assign instant_rpm = instant_reg;

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_IDX_PPR);
    assign prdata    = (paddr[2] == REG_IDX_PPR) ? DATA_W'(ppr_reg) : '0;

    // interval times pulses per revolution, one narrow multiply
    assign prod = DW'(elapsed_reg) * DW'(ppr_reg);

    // restoring divider step for the speed division: one quotient bit a cycle
    assign rem_sh   = {rem_reg, dvd_reg[QW-1]};
    assign rem_diff = rem_sh - {1'b0, div_reg};
    assign rem_ge   = (rem_sh >= {1'b0, div_reg});
    assign rem_next = rem_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
    assign quo_next = {quo_reg[QW-2:0], rem_ge};

    // saturate on a zero divisor or a quotient beyond 32 bits
    assign speed_sat = ((div_reg == '0) || (|quo_reg[QW-1:SPEED_W]))
                     ? SPEED_MAX : quo_reg[SPEED_W-1:0];

    // entries never written read as zero
    assign old_speed  = old_vld_reg ? rd_data_reg : '0;
    assign total_next = total_reg - TW'(old_speed) + TW'(speed_sat);
    assign pos_next   = (pos_reg == PW'(WINDOW_LEN - 1)) ? '0 : pos_reg + PW'(1);

    // window mean: upper digit from the top of the sum, lower digit from its remainder
    assign chunk_cur  = (state_reg == S_AVG_LO) ? {avg_rem_reg, total_reg[HALF_W-1:0]}
                                                : total_reg[TW-1:HALF_W];
    assign chunk_prod = {{MW{1'b0}}, chunk_cur} * {{CW{1'b0}}, RECIP};
    assign chunk_quo  = chunk_prod[RS +: HALF_W];
    assign chunk_rem  = total_reg[TW-1:HALF_W]
                      - CW'(avg_quo_reg[SPEED_W-1:HALF_W]) * CW'(WINDOW_LEN);

    // sequencer, architectural state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ppr_reg       <= PPR_RESET;
            prev_time_reg <= '0;
            seen_reg      <= 1'b0;
            pos_reg       <= '0;
            total_reg     <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            average_reg   <= '0;
            instant_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                ppr_reg <= pwdata[PPR_W-1:0];
            end

            // write-back keeps valid high: the result is either still pending or loaded now
            if (state_reg == S_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        prev_time_reg <= edge_time_us;
                        seen_reg      <= 1'b1;
                        // first edge only records its time
                        if (seen_reg)
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    cnt_reg   <= CNT_W'(NW - 1);
                    state_reg <= S_DIV_SPD;
                end
                S_DIV_SPD:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_SPD_END;
                    end
                end
                S_SPD_END:
                begin
                    total_reg        <= total_next;
                    vld_reg[pos_reg] <= 1'b1;
                    pos_reg          <= pos_next;
                    state_reg        <= S_AVG_HI;
                end
                S_AVG_HI:
                begin
                    state_reg <= S_AVG_REM;
                end
                S_AVG_REM:
                begin
                    state_reg <= S_AVG_LO;
                end
                S_AVG_LO:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // wait until the previous result has been taken
                    if (!out_valid_reg || out_take)
                    begin
                        average_reg   <= avg_quo_reg;
                        instant_reg   <= speed_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // divider and operand registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    elapsed_reg <= edge_time_us - prev_time_reg;
                    rd_data_reg <= ring_mem[pos_reg];
                    old_vld_reg <= vld_reg[pos_reg];
                end
            end
            S_MUL:
            begin
                div_reg <= prod;
                rem_reg <= '0;
                quo_reg <= '0;
                dvd_reg <= QW'(NUMER << (QW - NW));
            end
            S_DIV_SPD:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
            end
            S_SPD_END:
            begin
                speed_reg <= speed_sat;
            end
            S_AVG_HI:
            begin
                // sum over 2^32 is below WINDOW_LEN, so the upper digit fits 16 bits
                avg_quo_reg[SPEED_W-1:HALF_W] <= chunk_quo;
            end
            S_AVG_REM:
            begin
                avg_rem_reg <= chunk_rem[XW-1:0];
            end
            S_AVG_LO:
            begin
                avg_quo_reg[HALF_W-1:0] <= chunk_quo;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // ring write
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SPD_END)
        begin
            ring_mem[pos_reg] <= speed_sat;
        end
    end

`ifndef SYNTHESIS
    // a result appears only out of the final write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside write-back");

    // the speed division always runs its full length before the ring update
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPD_END) |-> $past(state_reg == S_DIV_SPD && cnt_reg == '0))
        else $error("speed division cut short");

    // ring position stays inside the window
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(WINDOW_LEN - 1))
        else $error("ring position out of range");

    // running sum never exceeds a full window of saturated speeds
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOTAL_MAX)
        else $error("window sum overflow");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(average_reg) && $stable(instant_reg))
        else $error("pending result overwritten");
`endif

endmodule
